/* hw/rtl/stt_pkg.sv */
// Shared types, codes and character classes for the source text tokenizer.
`timescale 1ns / 1ps
package stt_pkg;

   localparam int unsigned LINE_LIMIT_DEF   = 65535;
   localparam int unsigned COLUMN_LIMIT_DEF = 4095;
   localparam int unsigned LENGTH_LIMIT_DEF = 4095;

   localparam int RSP_DEPTH = 4;

   // token kinds
   localparam logic [4:0] KIND_END       = 5'd0;
   localparam logic [4:0] KIND_STRING    = 5'd1;
   localparam logic [4:0] KIND_WORD      = 5'd2;
   localparam logic [4:0] KIND_INTEGER   = 5'd3;
   localparam logic [4:0] KIND_FLOAT     = 5'd4;
   localparam logic [4:0] KIND_EQUAL     = 5'd5;
   localparam logic [4:0] KIND_RELATION  = 5'd6;
   localparam logic [4:0] KIND_MINUS     = 5'd7;
   localparam logic [4:0] KIND_PLUS      = 5'd8;
   localparam logic [4:0] KIND_DIVIDE    = 5'd9;
   localparam logic [4:0] KIND_MULTIPLY  = 5'd10;
   localparam logic [4:0] KIND_COLON     = 5'd11;
   localparam logic [4:0] KIND_SEMICOLON = 5'd12;
   localparam logic [4:0] KIND_LCURLY    = 5'd13;
   localparam logic [4:0] KIND_RCURLY    = 5'd14;
   localparam logic [4:0] KIND_LBRACKET  = 5'd15;
   localparam logic [4:0] KIND_RBRACKET  = 5'd16;
   localparam logic [4:0] KIND_LPAREN    = 5'd17;
   localparam logic [4:0] KIND_RPAREN    = 5'd18;
   localparam logic [4:0] KIND_COMMA     = 5'd19;
   localparam logic [4:0] KIND_ARROW     = 5'd20;

   // relational subtypes
   localparam logic [2:0] REL_GT = 3'd0;
   localparam logic [2:0] REL_LT = 3'd1;
   localparam logic [2:0] REL_GE = 3'd2;
   localparam logic [2:0] REL_LE = 3'd3;
   localparam logic [2:0] REL_EQ = 3'd4;
   localparam logic [2:0] REL_NE = 3'd5;

   // fault codes
   localparam logic [2:0] FAULT_NONE        = 3'd0;
   localparam logic [2:0] FAULT_OPEN_QUOTE  = 3'd1;
   localparam logic [2:0] FAULT_LONE_DOT    = 3'd2;
   localparam logic [2:0] FAULT_EXP_NODIGIT = 3'd3;
   localparam logic [2:0] FAULT_EXP_DOT     = 3'd4;
   localparam logic [2:0] FAULT_LONE_BANG   = 3'd5;
   localparam logic [2:0] FAULT_UNKNOWN     = 3'd6;
   localparam logic [2:0] FAULT_NONPRINT    = 3'd7;

   // characters
   localparam logic [7:0] CH_NL     = 8'h0A;
   localparam logic [7:0] CH_DQUOTE = 8'h22;
   localparam logic [7:0] CH_SQUOTE = 8'h27;
   localparam logic [7:0] CH_SLASH  = 8'h2F;
   localparam logic [7:0] CH_DOT    = 8'h2E;
   localparam logic [7:0] CH_PLUS   = 8'h2B;
   localparam logic [7:0] CH_MINUS  = 8'h2D;
   localparam logic [7:0] CH_EQ     = 8'h3D;
   localparam logic [7:0] CH_GT     = 8'h3E;
   localparam logic [7:0] CH_LT     = 8'h3C;
   localparam logic [7:0] CH_BANG   = 8'h21;
   localparam logic [7:0] CH_UNDER  = 8'h5F;
   localparam logic [7:0] CH_LOW_E  = 8'h65;
   localparam logic [7:0] CH_UP_E   = 8'h45;

   typedef enum logic [3:0] {
      MODE_IDLE,
      MODE_COMMENT,
      MODE_SLASH,
      MODE_STRING,
      MODE_WORD,
      MODE_INT,
      MODE_FRAC,
      MODE_EXP,
      MODE_EXPSIGN,
      MODE_EXPDIG,
      MODE_SYMBOL
   } scan_mode_type;

   typedef enum logic [2:0] {
      SYM_NONE,
      SYM_BANG,
      SYM_EQ,
      SYM_GT,
      SYM_LT,
      SYM_MINUS
   } pend_sym_type;

   typedef struct packed {
      logic [4:0]  token_kind;
      logic [2:0]  relation;
      logic [15:0] start_line;
      logic [11:0] start_column;
      logic [11:0] token_length;
      logic [2:0]  fault;
      logic        last;
   } rsp_word_type;

   // up to two result words per item, in order; v1 only with v0
   typedef struct packed {
      logic         v0;
      logic         v1;
      rsp_word_type w0;
      rsp_word_type w1;
   } push_type;

   function automatic logic is_digit(input logic [7:0] c);
      return (c >= 8'h30) && (c <= 8'h39);
   endfunction

   function automatic logic is_alpha(input logic [7:0] c);
      return ((c >= 8'h61) && (c <= 8'h7A)) || ((c >= 8'h41) && (c <= 8'h5A));
   endfunction

   function automatic logic is_space(input logic [7:0] c);
      return (c == 8'h20) || ((c >= 8'h09) && (c <= 8'h0D));
   endfunction

   function automatic logic is_accepted(input logic [7:0] c);
      return is_space(c) || ((c >= 8'h20) && (c <= 8'h7E));
   endfunction

   function automatic pend_sym_type sym_of(input logic [7:0] c);
      pend_sym_type s;
      s = SYM_NONE;
      unique case (c)
         CH_BANG:  s = SYM_BANG;
         CH_EQ:    s = SYM_EQ;
         CH_GT:    s = SYM_GT;
         CH_LT:    s = SYM_LT;
         CH_MINUS: s = SYM_MINUS;
         default:  s = SYM_NONE;
      endcase
      return s;
   endfunction

   // single-character punctuation; KIND_END when c is none of them
   function automatic logic [4:0] punct_kind(input logic [7:0] c);
      logic [4:0] k;
      k = KIND_END;
      unique case (c)
         8'h2B:   k = KIND_PLUS;
         8'h2A:   k = KIND_MULTIPLY;
         8'h3A:   k = KIND_COLON;
         8'h3B:   k = KIND_SEMICOLON;
         8'h7B:   k = KIND_LCURLY;
         8'h7D:   k = KIND_RCURLY;
         8'h5B:   k = KIND_LBRACKET;
         8'h5D:   k = KIND_RBRACKET;
         8'h28:   k = KIND_LPAREN;
         8'h29:   k = KIND_RPAREN;
         8'h2C:   k = KIND_COMMA;
         default: k = KIND_END;
      endcase
      return k;
   endfunction

endpackage

/* hw/rtl/stt_if.sv */
// Handshake channel interfaces for source words and token results.
`timescale 1ns / 1ps
interface stt_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] character;
   logic       end_of_text;

   modport source(output valid, character, end_of_text, input ready);
   modport sink(input valid, character, end_of_text, output ready);
endinterface

interface stt_rsp_if;
   logic        valid;
   logic        ready;
   logic [4:0]  token_kind;
   logic [2:0]  relation;
   logic [15:0] start_line;
   logic [11:0] start_column;
   logic [11:0] token_length;
   logic [2:0]  fault;
   logic        last;

   modport source(output valid, token_kind, relation, start_line, start_column,
                  token_length, fault, last, input ready);
   modport sink(input valid, token_kind, relation, start_line, start_column,
                token_length, fault, last, output ready);
endinterface

/* hw/rtl/source_text_tokenizer.sv */
// Top level of the streaming source text tokenizer.
//
//  channel  dir  word                                   accepted when
//  req      in   character, end_of_text                 req.valid && req.ready
//  rsp      out  token_kind .. fault, last              rsp.valid && rsp.ready
//
// Source words enter the input register, one per cycle while the result
// queue has room; the scanner updates its state from the registered word
// and queues 0, 1 or 2 results for rsp. The result port hands out one word
// per cycle while rsp.ready is high, so an item with two results drains as
// two words. Reset is synchronous; there is no clearing pass.
// req.ready drops only while the input register is full and the four-entry
// result queue has fewer than two free slots.
`timescale 1ns / 1ps
module source_text_tokenizer #(
   parameter int unsigned LINE_LIMIT   = stt_pkg::LINE_LIMIT_DEF,
   parameter int unsigned COLUMN_LIMIT = stt_pkg::COLUMN_LIMIT_DEF,
   parameter int unsigned LENGTH_LIMIT = stt_pkg::LENGTH_LIMIT_DEF
) (
   input logic       clock,
   input logic       reset,
   stt_req_if.sink   req,
   stt_rsp_if.source rsp
);
   import stt_pkg::*;

   push_type push;
   logic     room;

   stt_scan #(
      .LINE_LIMIT  (LINE_LIMIT),
      .COLUMN_LIMIT(COLUMN_LIMIT),
      .LENGTH_LIMIT(LENGTH_LIMIT)
   ) u_scan (
      .clock(clock),
      .reset(reset),
      .req  (req),
      .room (room),
      .push (push)
   );

   stt_fifo u_fifo (
      .clock(clock),
      .reset(reset),
      .push (push),
      .room (room),
      .rsp  (rsp)
   );

endmodule

/* hw/rtl/stt_scan.sv */
// Input register and scanner FSM: one word per cycle while room is set, into up to two results.
`timescale 1ns / 1ps
module stt_scan #(
   parameter int unsigned LINE_LIMIT   = stt_pkg::LINE_LIMIT_DEF,
   parameter int unsigned COLUMN_LIMIT = stt_pkg::COLUMN_LIMIT_DEF,
   parameter int unsigned LENGTH_LIMIT = stt_pkg::LENGTH_LIMIT_DEF
) (
   input  logic              clock,
   input  logic              reset,
   stt_req_if.sink           req,
   input  logic              room,
   output stt_pkg::push_type push
);
   import stt_pkg::*;

   localparam int LINE_BITS = $clog2(64'(LINE_LIMIT) + 64'd1);
   localparam int COL_BITS  = $clog2(64'(COLUMN_LIMIT) + 64'd1);
   localparam int LEN_BITS  = $clog2(64'(LENGTH_LIMIT) + 64'd1);
   localparam int LINE_W    = (LINE_BITS > 16) ? LINE_BITS : 16;
   localparam int COL_W     = (COL_BITS > 12) ? COL_BITS : 12;
   localparam int LEN_W     = (LEN_BITS > 12) ? LEN_BITS : 12;
   localparam logic [LINE_W-1:0] LINE_MAX = LINE_W'(LINE_LIMIT);
   localparam logic [COL_W-1:0]  COL_MAX  = COL_W'(COLUMN_LIMIT);
   localparam logic [LEN_W-1:0]  LEN_MAX  = LEN_W'(LENGTH_LIMIT);
   localparam logic [LINE_W-1:0] LINE_ONE = LINE_W'(1);
   localparam logic [LEN_W-1:0]  LEN_ONE  = LEN_W'(1);

   // input register
   logic       valid_ff, valid_in;
   logic [7:0] char_ff;
   logic       eot_ff;
   logic       consume;

   // scanner state
   scan_mode_type     mode_ff, mode_in;
   pend_sym_type      sym_ff, sym_in;
   logic              quote_ff, quote_in;
   logic [LINE_W-1:0] tline_ff, tline_in;
   logic [COL_W-1:0]  tcol_ff, tcol_in;
   logic [LEN_W-1:0]  tlen_ff, tlen_in;
   logic [LINE_W-1:0] line_ff, line_in;
   logic [COL_W-1:0]  col_ff, col_in;
   logic [2:0]        fault_ff, fault_in;

   // first result: pending token finished, or a fault
   logic              a_v;
   logic [4:0]        a_kind;
   logic [2:0]        a_rel;
   logic [2:0]        a_fault;
   logic [LINE_W-1:0] a_line;
   logic [COL_W-1:0]  a_col;
   logic [LEN_W-1:0]  a_len;
   // second result: one-character token, unknown character, or end token
   logic              b_v;
   logic [4:0]        b_kind;
   logic [2:0]        b_fault;
   logic              b_last;
   logic [LEN_W-1:0]  b_len;

   assign consume   = valid_ff && room;
   assign req.ready = !valid_ff || consume;
   assign valid_in  = req.ready ? req.valid : valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      if (req.valid && req.ready) begin
         char_ff <= req.character;
         eot_ff  <= req.end_of_text;
      end
   end

   // next state and result selection
   always_comb begin
      logic       is_end;
      logic       run;
      logic       cont;
      logic       do_grow;
      logic       do_emit;
      logic       do_fail;
      logic [4:0] e_kind;
      logic [2:0] e_rel;
      logic [2:0] f_code;
      logic       c_dig, c_alpha, c_nl, c_dot, c_e, c_eq, c_sign, c_quote;
      logic [4:0] pk;
      pend_sym_type ps;

      mode_in  = mode_ff;
      sym_in   = sym_ff;
      quote_in = quote_ff;
      tline_in = tline_ff;
      tcol_in  = tcol_ff;
      tlen_in  = tlen_ff;
      line_in  = line_ff;
      col_in   = col_ff;
      fault_in = fault_ff;

      a_v     = 1'b0;
      a_kind  = KIND_END;
      a_rel   = REL_GT;
      a_fault = FAULT_NONE;
      a_line  = line_ff;
      a_col   = col_ff;
      a_len   = '0;
      b_v     = 1'b0;
      b_kind  = KIND_END;
      b_fault = FAULT_NONE;
      b_last  = 1'b0;
      b_len   = '0;

      is_end  = eot_ff;
      run     = consume && (fault_ff == FAULT_NONE) && (eot_ff || is_accepted(char_ff));
      cont    = 1'b0;
      do_grow = 1'b0;
      do_emit = 1'b0;
      do_fail = 1'b0;
      e_kind  = KIND_END;
      e_rel   = REL_GT;
      f_code  = FAULT_NONE;

      c_dig   = !is_end && is_digit(char_ff);
      c_alpha = !is_end && (is_alpha(char_ff) || (char_ff == CH_UNDER));
      c_nl    = !is_end && (char_ff == CH_NL);
      c_dot   = !is_end && (char_ff == CH_DOT);
      c_e     = !is_end && ((char_ff == CH_LOW_E) || (char_ff == CH_UP_E));
      c_eq    = !is_end && (char_ff == CH_EQ);
      c_sign  = !is_end && ((char_ff == CH_PLUS) || (char_ff == CH_MINUS));
      c_quote = !is_end && (char_ff == (quote_ff ? CH_SQUOTE : CH_DQUOTE));
      pk      = punct_kind(char_ff);
      ps      = sym_of(char_ff);

      if (consume && !eot_ff && (fault_ff == FAULT_NONE) && !is_accepted(char_ff)) begin
         a_v      = 1'b1;
         a_fault  = FAULT_NONPRINT;
         fault_in = FAULT_NONPRINT;
      end

      if (run) begin
         // finish or extend the pending token
         unique case (mode_ff)
            MODE_COMMENT: begin
               if (c_nl || is_end) begin
                  mode_in = MODE_IDLE;
               end
            end
            MODE_SLASH: begin
               if (!is_end && (char_ff == CH_SLASH)) begin
                  mode_in = MODE_COMMENT;
               end else begin
                  do_emit = 1'b1; e_kind = KIND_DIVIDE; cont = 1'b1;
               end
            end
            MODE_STRING: begin
               if (c_quote) begin
                  do_emit = 1'b1; e_kind = KIND_STRING;
               end else if (c_nl || is_end) begin
                  do_fail = 1'b1; f_code = FAULT_OPEN_QUOTE;
               end else begin
                  do_grow = 1'b1;
               end
            end
            MODE_WORD: begin
               if (c_alpha || c_dig) begin
                  do_grow = 1'b1;
               end else begin
                  do_emit = 1'b1; e_kind = KIND_WORD; cont = 1'b1;
               end
            end
            MODE_INT: begin
               if (c_dig) begin
                  do_grow = 1'b1;
               end else if (c_dot) begin
                  do_grow = 1'b1; mode_in = MODE_FRAC;
               end else if (c_e) begin
                  do_grow = 1'b1; mode_in = MODE_EXP;
               end else begin
                  do_emit = 1'b1; e_kind = KIND_INTEGER; cont = 1'b1;
               end
            end
            MODE_FRAC: begin
               if (c_dig) begin
                  do_grow = 1'b1;
               end else if (tlen_ff == LEN_ONE) begin
                  do_fail = 1'b1; f_code = FAULT_LONE_DOT;
               end else if (c_e) begin
                  do_grow = 1'b1; mode_in = MODE_EXP;
               end else begin
                  do_emit = 1'b1; e_kind = KIND_FLOAT; cont = 1'b1;
               end
            end
            MODE_EXP: begin
               if (c_sign) begin
                  do_grow = 1'b1; mode_in = MODE_EXPSIGN;
               end else if (c_dig) begin
                  do_grow = 1'b1; mode_in = MODE_EXPDIG;
               end else begin
                  do_fail = 1'b1; f_code = FAULT_EXP_NODIGIT;
               end
            end
            MODE_EXPSIGN: begin
               if (c_dig) begin
                  do_grow = 1'b1; mode_in = MODE_EXPDIG;
               end else begin
                  do_fail = 1'b1; f_code = FAULT_EXP_NODIGIT;
               end
            end
            MODE_EXPDIG: begin
               if (c_dig) begin
                  do_grow = 1'b1;
               end else if (c_dot) begin
                  do_fail = 1'b1; f_code = FAULT_EXP_DOT;
               end else begin
                  do_emit = 1'b1; e_kind = KIND_FLOAT; cont = 1'b1;
               end
            end
            MODE_SYMBOL: begin
               unique case (sym_ff)
                  SYM_BANG: begin
                     if (c_eq) begin
                        do_grow = 1'b1; do_emit = 1'b1;
                        e_kind = KIND_RELATION; e_rel = REL_NE;
                     end else begin
                        do_fail = 1'b1; f_code = FAULT_LONE_BANG;
                     end
                  end
                  SYM_EQ: begin
                     do_emit = 1'b1;
                     if (c_eq) begin
                        do_grow = 1'b1; e_kind = KIND_RELATION; e_rel = REL_EQ;
                     end else begin
                        e_kind = KIND_EQUAL; cont = 1'b1;
                     end
                  end
                  SYM_GT: begin
                     do_emit = 1'b1; e_kind = KIND_RELATION;
                     if (c_eq) begin
                        do_grow = 1'b1; e_rel = REL_GE;
                     end else begin
                        e_rel = REL_GT; cont = 1'b1;
                     end
                  end
                  SYM_LT: begin
                     do_emit = 1'b1; e_kind = KIND_RELATION;
                     if (c_eq) begin
                        do_grow = 1'b1; e_rel = REL_LE;
                     end else begin
                        e_rel = REL_LT; cont = 1'b1;
                     end
                  end
                  default: begin
                     do_emit = 1'b1;
                     if (!is_end && (char_ff == CH_GT)) begin
                        do_grow = 1'b1; e_kind = KIND_ARROW;
                     end else begin
                        e_kind = KIND_MINUS; cont = 1'b1;
                     end
                  end
               endcase
            end
            default: begin
               mode_in = MODE_IDLE;
               cont    = 1'b1;
            end
         endcase

         if (do_grow && (tlen_in < LEN_MAX)) begin
            tlen_in = tlen_in + LEN_ONE;
         end
         if (do_emit) begin
            a_v    = 1'b1;
            a_kind = e_kind;
            a_rel  = e_rel;
            a_line = tline_ff;
            a_col  = tcol_ff;
            a_len  = tlen_in;
         end
         if (do_fail) begin
            a_v      = 1'b1;
            a_fault  = f_code;
            fault_in = f_code;
         end
         if (do_emit || do_fail) begin
            mode_in = MODE_IDLE;
            sym_in  = SYM_NONE;
         end

         // open a new token with this character, emit it as a one-character token, or flag it as unknown
         if (cont && !is_end && !is_space(char_ff)) begin
            tline_in = line_ff;
            tcol_in  = col_ff;
            tlen_in  = LEN_ONE;
            if (char_ff == CH_SLASH) begin
               mode_in = MODE_SLASH;
            end else if ((char_ff == CH_DQUOTE) || (char_ff == CH_SQUOTE)) begin
               tlen_in  = '0;
               quote_in = (char_ff == CH_SQUOTE);
               mode_in  = MODE_STRING;
            end else if (c_alpha) begin
               mode_in = MODE_WORD;
            end else if (c_dig) begin
               mode_in = MODE_INT;
            end else if (c_dot) begin
               mode_in = MODE_FRAC;
            end else if (ps != SYM_NONE) begin
               sym_in  = ps;
               mode_in = MODE_SYMBOL;
            end else if (pk != KIND_END) begin
               b_v    = 1'b1;
               b_kind = pk;
               b_len  = LEN_ONE;
            end else begin
               tline_in = tline_ff;
               tcol_in  = tcol_ff;
               tlen_in  = tlen_ff;
               b_v      = 1'b1;
               b_fault  = FAULT_UNKNOWN;
               fault_in = FAULT_UNKNOWN;
            end
         end

         if (!is_end) begin
            if (c_nl) begin
               if (line_ff < LINE_MAX) begin
                  line_in = line_ff + LINE_ONE;
               end
               col_in = '0;
            end else if (col_ff < COL_MAX) begin
               col_in = col_ff + COL_W'(1);
            end
         end
      end

      // end of text: report the sticky fault, including one raised by this word, then start over
      if (consume && eot_ff) begin
         b_v      = 1'b1;
         b_kind   = KIND_END;
         b_fault  = fault_in;
         b_last   = 1'b1;
         b_len    = '0;
         mode_in  = MODE_IDLE;
         sym_in   = SYM_NONE;
         quote_in = 1'b0;
         tline_in = LINE_ONE;
         tcol_in  = '0;
         tlen_in  = '0;
         line_in  = LINE_ONE;
         col_in   = '0;
         fault_in = FAULT_NONE;
      end
   end

   // pack results in order
   always_comb begin
      rsp_word_type wa;
      rsp_word_type wb;

      wa.token_kind   = a_kind;
      wa.relation     = a_rel;
      wa.start_line   = a_line[15:0];
      wa.start_column = a_col[11:0];
      wa.token_length = a_len[11:0];
      wa.fault        = a_fault;
      wa.last         = 1'b0;

      wb.token_kind   = b_kind;
      wb.relation     = REL_GT;
      wb.start_line   = line_ff[15:0];
      wb.start_column = col_ff[11:0];
      wb.token_length = b_len[11:0];
      wb.fault        = b_fault;
      wb.last         = b_last;

      push.v0 = a_v || b_v;
      push.v1 = a_v && b_v;
      push.w0 = a_v ? wa : wb;
      push.w1 = wb;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff  <= MODE_IDLE;
         sym_ff   <= SYM_NONE;
         quote_ff <= 1'b0;
         tline_ff <= LINE_ONE;
         tcol_ff  <= '0;
         tlen_ff  <= '0;
         line_ff  <= LINE_ONE;
         col_ff   <= '0;
         fault_ff <= FAULT_NONE;
      end else begin
         mode_ff  <= mode_in;
         sym_ff   <= sym_in;
         quote_ff <= quote_in;
         tline_ff <= tline_in;
         tcol_ff  <= tcol_in;
         tlen_ff  <= tlen_in;
         line_ff  <= line_in;
         col_ff   <= col_in;
         fault_ff <= fault_in;
      end
   end

endmodule

/* hw/rtl/stt_fifo.sv */
// Result queue: takes up to two words a cycle, hands out one while rsp.ready is high.
`timescale 1ns / 1ps
module stt_fifo (
   input  logic              clock,
   input  logic              reset,
   input  stt_pkg::push_type push,
   output logic              room,
   stt_rsp_if.source         rsp
);
   import stt_pkg::*;

   localparam int PTR_W = $clog2(RSP_DEPTH);
   localparam int CNT_W = $clog2(RSP_DEPTH + 1);
   localparam logic [CNT_W-1:0] ROOM_MAX = CNT_W'(RSP_DEPTH - 2);

   rsp_word_type     mem_ff [RSP_DEPTH];
   logic [PTR_W-1:0] wr_ff, wr_in;
   logic [PTR_W-1:0] rd_ff, rd_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic             pop;
   rsp_word_type     head;

   // accept a new item only with space for both of its words
   assign room = (cnt_ff <= ROOM_MAX);
   assign pop  = rsp.valid && rsp.ready;
   assign head = mem_ff[rd_ff];

   assign rsp.valid        = (cnt_ff != '0);
   assign rsp.token_kind   = head.token_kind;
   assign rsp.relation     = head.relation;
   assign rsp.start_line   = head.start_line;
   assign rsp.start_column = head.start_column;
   assign rsp.token_length = head.token_length;
   assign rsp.fault        = head.fault;
   assign rsp.last         = head.last;

   always_comb begin
      wr_in  = wr_ff + PTR_W'(push.v0) + PTR_W'(push.v1);
      rd_in  = rd_ff + PTR_W'(pop);
      cnt_in = cnt_ff + CNT_W'(push.v0) + CNT_W'(push.v1) - CNT_W'(pop);
   end

   always_ff @(posedge clock) begin
      if (push.v0) begin
         mem_ff[wr_ff] <= push.w0;
      end
      if (push.v1) begin
         mem_ff[wr_ff + PTR_W'(1)] <= push.w1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
   end

endmodule
